>>> hdl/sphm_pkg.sv
// Shared constants, codes and color tables for the spectrum peak hold meter.
package sphm_pkg;

    localparam int NUM_BINS = 64;
    localparam int BIN_W    = (NUM_BINS > 2) ? $clog2(NUM_BINS) : 1;
    localparam int LVL_W    = 17;
    localparam int DECAY_W  = 16;
    localparam int HGT_W    = 10;
    localparam int CFG_W    = 17;
    localparam int CIDX_W   = 2;

    localparam logic [LVL_W-1:0] FULL_SCALE = 17'h10000;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_DECAY  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FLOOR  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [DECAY_W-1:0] DECAY_RST  = 16'd60293;
    localparam logic [LVL_W-1:0]   FLOOR_RST  = 17'd131;
    localparam logic [HGT_W-1:0]   HEIGHT_RST = 10'd60;

    typedef logic [7:0] color_tab_t [NUM_BINS];

    // base + floor(bin * span / NUM_BINS), evaluated at elaboration
    function automatic color_tab_t make_color_tab(int base, int span);
        color_tab_t tab;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            tab[i] = 8'((base + (i * span) / NUM_BINS) % 256);
        end
        return tab;
    endfunction

    localparam color_tab_t RED_TAB   = make_color_tab(21, 234);
    localparam color_tab_t GREEN_TAB = make_color_tab(101, 154);
    localparam color_tab_t BLUE_TAB  = make_color_tab(192, 63);

endpackage

>>> hdl/spectrum_peak_hold_meter.sv
// Top level: per-bin level and held-peak store with decay and display scaling.
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+--------------------------------------
//  in      | in        | in_valid / in_stall  | action, bin_index, level
//  out     | out       | out_valid / out_stall| bar_height, peak_height, peak_visible,
//          |           |                      | red, green, blue, redraw
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Sample and read beats: memory read, then ST_RMW, where a sample read-modify-writes the
//   level and peak memories; the result loads in ST_OUT, height scaling in front.
// Unused action code: straight to ST_OUT, where the result loads. Decay tick: one bin
//   a cycle, then the result loads in ST_OUT.
// One beat is in flight at a time: in_stall is high from accept until the result loads.
// Reset clears per-bin valid bits at once, so no clearing pass is needed; an
// entry not written since reset reads as zero.
// A stalled output holds the machine in its final state until the register frees.
module spectrum_peak_hold_meter
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input beats
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        action,
    input  logic [5:0]                        bin_index,
    input  logic [sphm_pkg::LVL_W-1:0]        level,
    // result beats
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sphm_pkg::HGT_W-1:0]        bar_height,
    output logic [sphm_pkg::HGT_W-1:0]        peak_height,
    output logic                              peak_visible,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic                              redraw,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sphm_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [sphm_pkg::CFG_W-1:0]        cfg_data
);

    localparam int BIN_W = sphm_pkg::BIN_W;
    localparam int LVL_W = sphm_pkg::LVL_W;
    localparam int HGT_W = sphm_pkg::HGT_W;
    localparam int DEC_W = sphm_pkg::DECAY_W;
    localparam int NB    = sphm_pkg::NUM_BINS;

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_RMW  = 4'b0010,
        ST_TICK = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    // configuration
    logic [DEC_W-1:0] decay_reg;
    logic [LVL_W-1:0] floor_reg;
    logic [HGT_W-1:0] height_reg;

    // control
    state_t           state_reg, state_next;
    logic [1:0]       act_reg, act_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [BIN_W-1:0] tick_idx_reg, tick_idx_next;
    logic             changed_reg, changed_next;
    logic             report_reg, report_next;
    logic             redraw_reg, redraw_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [LVL_W-1:0] pk_reg, pk_next;
    logic [NB-1:0]    vld_reg;

    // memories and their read registers
    logic [LVL_W-1:0] level_mem [NB];
    logic [LVL_W-1:0] peak_mem  [NB];
    logic [LVL_W-1:0] lvl_rd_reg;
    logic [LVL_W-1:0] pk_rd_reg;
    logic             vld_rd_reg;

    // output register
    logic             out_valid_reg;
    logic [HGT_W-1:0] bar_reg;
    logic [HGT_W-1:0] peak_h_reg;
    logic             vis_reg;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;
    logic             redraw_out_reg;

    logic                   accept;
    logic                   in_range;
    logic [BIN_W-1:0]       bin_addr;
    logic [LVL_W-1:0]       lvl_sat;
    logic [BIN_W-1:0]       rd_addr;
    logic [BIN_W-1:0]       wr_addr;
    logic                   level_we;
    logic                   peak_we;
    logic [LVL_W-1:0]       peak_wdata;
    logic [LVL_W-1:0]       cur_lvl;
    logic [LVL_W-1:0]       cur_pk;
    logic [LVL_W-1:0]       max_pk;
    logic [LVL_W+DEC_W-1:0] decay_prod;
    logic                   above_floor;
    logic                   load_out;
    logic [LVL_W+HGT_W-1:0] bar_prod;
    logic [LVL_W+HGT_W-1:0] peak_prod;
    logic [HGT_W-1:0]       peak_h;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign in_range  = (int'(bin_index) < NB);
    assign bin_addr  = BIN_W'(bin_index);
    assign lvl_sat   = (level > sphm_pkg::FULL_SCALE) ? sphm_pkg::FULL_SCALE : level;

    // entries never written since reset read as zero
    assign cur_lvl     = vld_rd_reg ? lvl_rd_reg : '0;
    assign cur_pk      = vld_rd_reg ? pk_rd_reg  : '0;
    assign max_pk      = (lvl_reg > cur_pk) ? lvl_reg : cur_pk;
    assign decay_prod  = cur_pk * decay_reg;
    assign above_floor = (cur_pk > floor_reg);

    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign bar_prod  = lvl_reg * height_reg;
    assign peak_prod = pk_reg * height_reg;
    assign peak_h    = peak_prod[HGT_W+15:16];

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg  <= sphm_pkg::DECAY_RST;
            floor_reg  <= sphm_pkg::FLOOR_RST;
            height_reg <= sphm_pkg::HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sphm_pkg::CFG_DECAY:  decay_reg  <= cfg_data[DEC_W-1:0];
                sphm_pkg::CFG_FLOOR:  floor_reg  <= cfg_data[LVL_W-1:0];
                sphm_pkg::CFG_HEIGHT: height_reg <= cfg_data[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // read address: the addressed bin (bin 0 for a tick) at accept, next bin in a tick
    always_comb
    begin
        case (state_reg)
            ST_TICK: rd_addr = tick_idx_reg + 1'b1;
            default: rd_addr = (action == sphm_pkg::ACT_TICK) ? '0 : bin_addr;
        endcase
    end

    // main sequencer
    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        bin_next      = bin_reg;
        tick_idx_next = tick_idx_reg;
        changed_next  = changed_reg;
        report_next   = report_reg;
        redraw_next   = redraw_reg;
        lvl_next      = lvl_reg;
        pk_next       = pk_reg;
        level_we      = 1'b0;
        peak_we       = 1'b0;
        wr_addr       = bin_reg;
        peak_wdata    = max_pk;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next      = action;
                    bin_next      = bin_addr;
                    lvl_next      = lvl_sat;
                    tick_idx_next = '0;
                    changed_next  = 1'b0;
                    report_next   = 1'b0;
                    redraw_next   = 1'b0;
                    case (action)
                        sphm_pkg::ACT_TICK:   state_next = ST_TICK;
                        sphm_pkg::ACT_SAMPLE,
                        sphm_pkg::ACT_READ:   state_next = in_range ? ST_RMW : ST_OUT;
                        default:              state_next = ST_OUT;
                    endcase
                end
            end
            ST_RMW:
            begin
                report_next = 1'b1;
                if (act_reg == sphm_pkg::ACT_SAMPLE)
                begin
                    level_we    = 1'b1;
                    peak_we     = 1'b1;
                    pk_next     = max_pk;
                    redraw_next = 1'b1;
                end
                else
                begin
                    lvl_next = cur_lvl;
                    pk_next  = cur_pk;
                end
                state_next = ST_OUT;
            end
            ST_TICK:
            begin
                wr_addr      = tick_idx_reg;
                peak_wdata   = decay_prod[LVL_W+15:16];
                peak_we      = above_floor;
                changed_next = changed_reg || above_floor;
                tick_idx_next = tick_idx_reg + 1'b1;
                if (tick_idx_reg == BIN_W'(NB - 1))
                begin
                    redraw_next = changed_reg || above_floor;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            act_reg      <= sphm_pkg::ACT_SAMPLE;
            bin_reg      <= '0;
            tick_idx_reg <= '0;
            changed_reg  <= 1'b0;
            report_reg   <= 1'b0;
            redraw_reg   <= 1'b0;
            vld_reg      <= '0;
            vld_rd_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            act_reg      <= act_next;
            bin_reg      <= bin_next;
            tick_idx_reg <= tick_idx_next;
            changed_reg  <= changed_next;
            report_reg   <= report_next;
            redraw_reg   <= redraw_next;
            vld_rd_reg   <= vld_reg[rd_addr];
            if (level_we)
                vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
        pk_reg  <= pk_next;
    end

    // level memory
    always_ff @(posedge clk)
    begin
        if (level_we)
            level_mem[wr_addr] <= lvl_reg;
        lvl_rd_reg <= level_mem[rd_addr];
    end

    // peak memory
    always_ff @(posedge clk)
    begin
        if (peak_we)
            peak_mem[wr_addr] <= peak_wdata;
        pk_rd_reg <= peak_mem[rd_addr];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            redraw_out_reg <= redraw_reg;
            if (report_reg)
            begin
                bar_reg    <= bar_prod[HGT_W+15:16];
                peak_h_reg <= peak_h;
                vis_reg    <= (peak_h > HGT_W'(2));
                red_reg    <= sphm_pkg::RED_TAB[bin_reg];
                green_reg  <= sphm_pkg::GREEN_TAB[bin_reg];
                blue_reg   <= sphm_pkg::BLUE_TAB[bin_reg];
            end
            else
            begin
                bar_reg    <= '0;
                peak_h_reg <= '0;
                vis_reg    <= 1'b0;
                red_reg    <= '0;
                green_reg  <= '0;
                blue_reg   <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign bar_height   = bar_reg;
    assign peak_height  = peak_h_reg;
    assign peak_visible = vis_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign redraw       = redraw_out_reg;

endmodule

>>> hdl/sphm_checker.sv
// Port-level checker for the spectrum peak hold meter, bound to the top level.
module sphm_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [1:0]                  action,
    input logic [5:0]                  bin_index,
    input logic [sphm_pkg::LVL_W-1:0]  level,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [sphm_pkg::HGT_W-1:0]  bar_height,
    input logic [sphm_pkg::HGT_W-1:0]  peak_height,
    input logic                        peak_visible,
    input logic [7:0]                  red,
    input logic [7:0]                  green,
    input logic [7:0]                  blue,
    input logic                        redraw,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic [sphm_pkg::CIDX_W-1:0] cfg_index,
    input logic [sphm_pkg::CFG_W-1:0]  cfg_data
);

    // one beat in flight: an accepted beat blocks the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(peak_height) && $stable(redraw)
            && $stable(bar_height) && $stable(red))
        else $error("stalled result changed");

    // visibility flag follows peak height
    a_visible: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (peak_visible == (peak_height > 10'd2)))
        else $error("peak_visible inconsistent with peak_height");

    // a sample report never shows the bar above its peak
    a_sample_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && redraw && (red != 8'd0) |-> peak_height >= bar_height)
        else $error("sample result with bar above peak");

    // a result without a bin report is all zero apart from redraw
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (red == 8'd0) |-> (green == 8'd0) && (blue == 8'd0)
            && (bar_height == '0) && (peak_height == '0) && !peak_visible)
        else $error("partial bin report");

endmodule

bind spectrum_peak_hold_meter sphm_checker u_sphm_checker (.*);
